>>> sv/fcgm_pkg.sv
`default_nettype none

package fcgm_pkg;

  // Widest cell the column mask is built for.
  localparam int MAX_CELL_WIDTH_DEF = 64;

  // Configuration channel widths.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;

  // Register field widths.
  localparam int CELL_SIZE_W  = 7;
  localparam int CELL_COUNT_W = 9;

  // Pixel and glyph record field widths.
  localparam int ALPHA_W        = 8;
  localparam int GLYPH_NUM_W    = 16;
  localparam int ADVANCE_W      = 7;
  localparam int BEARING_W      = 7;
  localparam int TEX_COORD_W    = 14;
  localparam int GLYPH_WIDTH_W  = 8;
  localparam int GLYPH_HEIGHT_W = 6;

  // Position counter widths.
  localparam int ROW_W      = 6;
  localparam int CELL_POS_W = 8;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CELL_WIDTH   = 3'd0,
    REG_CELL_HEIGHT  = 3'd1,
    REG_CELLS_ACROSS = 3'd2,
    REG_CELLS_DOWN   = 3'd3
  } cfg_reg_t;

endpackage

`default_nettype wire

>>> sv/fcgm_pixel_if.sv
`default_nettype none

interface fcgm_pixel_if
  import fcgm_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [ALPHA_W-1:0] pixel_alpha;

  modport source (output valid, output pixel_alpha, input ready);
  modport sink (input valid, input pixel_alpha, output ready);
endinterface

`default_nettype wire

>>> sv/fcgm_glyph_if.sv
`default_nettype none

interface fcgm_glyph_if
  import fcgm_pkg::*;
;
  logic                             valid;
  logic                             ready;
  logic        [GLYPH_NUM_W-1:0]    glyph_number;
  logic        [ADVANCE_W-1:0]      advance;
  logic signed [BEARING_W-1:0]      bearing;
  logic        [TEX_COORD_W-1:0]    atlas_x;
  logic        [TEX_COORD_W-1:0]    atlas_y;
  logic signed [GLYPH_WIDTH_W-1:0]  glyph_width;
  logic        [GLYPH_HEIGHT_W-1:0] glyph_height;

  modport source (
    output valid, output glyph_number, output advance, output bearing,
    output atlas_x, output atlas_y, output glyph_width, output glyph_height,
    input ready
  );
  modport sink (
    input valid, input glyph_number, input advance, input bearing,
    input atlas_x, input atlas_y, input glyph_width, input glyph_height,
    output ready
  );
endinterface

`default_nettype wire

>>> sv/fcgm_cfg_if.sv
`default_nettype none

interface fcgm_cfg_if
  import fcgm_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> sv/font_cell_glyph_metrics.sv
`default_nettype none

// A glyph record passes three registers after the edge that accepts the last pixel
// of its cell: cell snapshot, edge search and products, output register.
// Throughput: one pixel per cycle; the pixel input stalls only in reset or when all
// three record stages hold records that the sink has not taken.
// Reset: registers return to 8x8 pixel cells in a 16x16 atlas and the stream restarts
// at pixel zero of cell zero. A write to a known register also restarts the stream.
module font_cell_glyph_metrics
  import fcgm_pkg::*;
#(
  parameter int MAX_CELL_WIDTH = MAX_CELL_WIDTH_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  fcgm_pixel_if.sink        in_pix,
  fcgm_glyph_if.source      out_glyph,
  fcgm_cfg_if.sink          cfg_wr
);

  localparam int COL_W = (MAX_CELL_WIDTH > 1) ? $clog2(MAX_CELL_WIDTH) : 1;
  localparam int CNT_W = $clog2(MAX_CELL_WIDTH + 1);

  // Configuration registers.
  logic [CELL_SIZE_W-1:0]  cell_width_r;
  logic [CELL_SIZE_W-1:0]  cell_height_r;
  logic [CELL_COUNT_W-1:0] cells_across_r;
  logic [CELL_COUNT_W-1:0] cells_down_r;

  logic [CNT_W-1:0]        eff_w;
  logic [CELL_SIZE_W-1:0]  eff_h;
  logic [CELL_COUNT_W-1:0] eff_across;
  logic [CELL_COUNT_W-1:0] eff_down;

  // Stream position and per-cell state.
  logic [COL_W-1:0]               col_r, col_nxt;
  logic [ROW_W-1:0]               row_r, row_nxt;
  logic [CELL_POS_W-1:0]          cell_col_r, cell_col_nxt;
  logic [CELL_POS_W-1:0]          cell_row_r, cell_row_nxt;
  logic [MAX_CELL_WIDTH-1:0]      mask_r, mask_nxt;
  logic signed [ADVANCE_W-1:0]    run_start_r, run_start_nxt;
  logic [ADVANCE_W-1:0]           run_end_r, run_end_nxt;
  logic                           run_closed_r, run_closed_nxt;

  logic pix_accept;
  logic cfg_accept;
  logic cfg_hit;
  logic last_col;
  logic last_row;
  logic cell_end;

  // Record pipeline stage A: cell snapshot.
  logic                          a_valid_r;
  logic [MAX_CELL_WIDTH-1:0]     a_mask_r;
  logic signed [ADVANCE_W-1:0]   a_run_start_r;
  logic [ADVANCE_W-1:0]          a_run_end_r;
  logic [CELL_POS_W-1:0]         a_cell_col_r;
  logic [CELL_POS_W-1:0]         a_cell_row_r;

  // Stage B: ink edges and products.
  logic                          b_valid_r;
  logic [CNT_W-1:0]              b_lead_r, b_lead_nxt;
  logic [CNT_W-1:0]              b_trail_r, b_trail_nxt;
  logic [CELL_POS_W+CELL_SIZE_W-1:0]  b_prod_x_r;
  logic [CELL_POS_W+CELL_SIZE_W-1:0]  b_prod_y_r;
  logic [CELL_POS_W+CELL_COUNT_W-1:0] b_prod_n_r;
  logic signed [ADVANCE_W-1:0]   b_run_start_r;
  logic [ADVANCE_W-1:0]          b_run_end_r;
  logic [CELL_POS_W-1:0]         b_cell_col_r;
  logic [COL_W-1:0]              hi_idx;
  logic                          ink_found;

  // Output register.
  logic                             out_valid_r;
  logic [GLYPH_NUM_W-1:0]           glyph_number_r;
  logic [ADVANCE_W-1:0]             advance_r;
  logic signed [BEARING_W-1:0]      bearing_r;
  logic [TEX_COORD_W-1:0]           atlas_x_r;
  logic [TEX_COORD_W-1:0]           atlas_y_r;
  logic signed [GLYPH_WIDTH_W-1:0]  glyph_width_r;
  logic [GLYPH_HEIGHT_W-1:0]        glyph_height_r;
  logic [CNT_W-1:0]                 ink_start;

  logic out_en;
  logic b_en;
  logic a_en;

  // Saturate each register to its legal range.
  always_comb begin
    if (cell_width_r < CELL_SIZE_W'(2)) begin
      eff_w = CNT_W'(2);
    end else if (cell_width_r > CELL_SIZE_W'(MAX_CELL_WIDTH)) begin
      eff_w = CNT_W'(MAX_CELL_WIDTH);
    end else begin
      eff_w = CNT_W'(cell_width_r);
    end

    if (cell_height_r < CELL_SIZE_W'(2)) begin
      eff_h = CELL_SIZE_W'(2);
    end else if (cell_height_r > CELL_SIZE_W'(64)) begin
      eff_h = CELL_SIZE_W'(64);
    end else begin
      eff_h = cell_height_r;
    end

    if (cells_across_r == '0) begin
      eff_across = CELL_COUNT_W'(1);
    end else if (cells_across_r > CELL_COUNT_W'(256)) begin
      eff_across = CELL_COUNT_W'(256);
    end else begin
      eff_across = cells_across_r;
    end

    if (cells_down_r == '0) begin
      eff_down = CELL_COUNT_W'(1);
    end else if (cells_down_r > CELL_COUNT_W'(256)) begin
      eff_down = CELL_COUNT_W'(256);
    end else begin
      eff_down = cells_down_r;
    end
  end

  // Handshakes: the record pipeline advances whenever the stage after it can take data.
  assign out_en     = !out_valid_r || out_glyph.ready;
  assign b_en       = !b_valid_r || out_en;
  assign a_en       = !a_valid_r || b_en;
  assign in_pix.ready = a_en && rst_n;
  assign cfg_wr.ready = rst_n;
  assign pix_accept = in_pix.valid && in_pix.ready;
  assign cfg_accept = cfg_wr.valid && cfg_wr.ready;

  always_comb begin
    cfg_hit = 1'b0;
    unique case (cfg_reg_t'(cfg_wr.index))
      REG_CELL_WIDTH, REG_CELL_HEIGHT, REG_CELLS_ACROSS, REG_CELLS_DOWN: cfg_hit = 1'b1;
      default: cfg_hit = 1'b0;
    endcase
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_width_r   <= CELL_SIZE_W'(8);
      cell_height_r  <= CELL_SIZE_W'(8);
      cells_across_r <= CELL_COUNT_W'(16);
      cells_down_r   <= CELL_COUNT_W'(16);
    end else if (cfg_accept) begin
      unique case (cfg_reg_t'(cfg_wr.index))
        REG_CELL_WIDTH:   cell_width_r   <= cfg_wr.data[CELL_SIZE_W-1:0];
        REG_CELL_HEIGHT:  cell_height_r  <= cfg_wr.data[CELL_SIZE_W-1:0];
        REG_CELLS_ACROSS: cells_across_r <= cfg_wr.data[CELL_COUNT_W-1:0];
        REG_CELLS_DOWN:   cells_down_r   <= cfg_wr.data[CELL_COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Position decode for the current pixel.
  assign last_col = (CNT_W'(col_r) == eff_w - CNT_W'(1));
  assign last_row = ({1'b0, row_r} == eff_h - CELL_SIZE_W'(1));
  assign cell_end = last_col && last_row;

  // Per-pixel update: ink columns in the ink rows, transparent run in the metrics row.
  always_comb begin
    mask_nxt       = mask_r;
    run_start_nxt  = run_start_r;
    run_end_nxt    = run_end_r;
    run_closed_nxt = run_closed_r;
    if (!last_row) begin
      if (in_pix.pixel_alpha != '0) begin
        mask_nxt[col_r] = 1'b1;
      end
    end else if (run_start_r[ADVANCE_W-1]) begin
      if (in_pix.pixel_alpha == '0) begin
        run_start_nxt = signed'(ADVANCE_W'(col_r));
      end
    end else if (!run_closed_r && (in_pix.pixel_alpha != '0)) begin
      run_end_nxt    = ADVANCE_W'(col_r);
      run_closed_nxt = 1'b1;
    end
  end

  // Position counters step through the cell, then through the atlas.
  always_comb begin
    col_nxt      = col_r + COL_W'(1);
    row_nxt      = row_r;
    cell_col_nxt = cell_col_r;
    cell_row_nxt = cell_row_r;
    if (last_col) begin
      col_nxt = '0;
      row_nxt = row_r + ROW_W'(1);
      if (last_row) begin
        row_nxt = '0;
        if ({1'b0, cell_col_r} + CELL_COUNT_W'(1) >= eff_across) begin
          cell_col_nxt = '0;
          if ({1'b0, cell_row_r} + CELL_COUNT_W'(1) >= eff_down) begin
            cell_row_nxt = '0;
          end else begin
            cell_row_nxt = cell_row_r + CELL_POS_W'(1);
          end
        end else begin
          cell_col_nxt = cell_col_r + CELL_POS_W'(1);
        end
      end
    end
  end

  // Stream state registers; a write to a known register restarts the stream.
  always_ff @(posedge clk) begin
    if (!rst_n || (cfg_accept && cfg_hit)) begin
      col_r        <= '0;
      row_r        <= '0;
      cell_col_r   <= '0;
      cell_row_r   <= '0;
      mask_r       <= '0;
      run_start_r  <= '1;
      run_closed_r <= 1'b0;
    end else if (pix_accept) begin
      col_r        <= col_nxt;
      row_r        <= row_nxt;
      cell_col_r   <= cell_col_nxt;
      cell_row_r   <= cell_row_nxt;
      if (cell_end) begin
        mask_r       <= '0;
        run_start_r  <= '1;
        run_closed_r <= 1'b0;
      end else begin
        mask_r       <= mask_nxt;
        run_start_r  <= run_start_nxt;
        run_closed_r <= run_closed_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pix_accept) begin
      run_end_r <= run_end_nxt;
    end
  end

  // Stage A: snapshot of the finished cell. An open run ends at the cell edge.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (a_en) begin
      a_valid_r <= pix_accept && cell_end;
    end
  end

  always_ff @(posedge clk) begin
    if (a_en && pix_accept && cell_end) begin
      a_mask_r      <= mask_nxt;
      a_run_start_r <= run_start_nxt;
      a_run_end_r   <= run_closed_nxt ? run_end_nxt : ADVANCE_W'(eff_w);
      a_cell_col_r  <= cell_col_r;
      a_cell_row_r  <= cell_row_r;
    end
  end

  // Leading and trailing clear columns of the ink mask.
  always_comb begin
    b_lead_nxt = eff_w;
    for (int i = MAX_CELL_WIDTH - 1; i >= 0; i--) begin
      if (a_mask_r[i]) begin
        b_lead_nxt = CNT_W'(i);
      end
    end
    hi_idx    = '0;
    ink_found = 1'b0;
    for (int i = 0; i < MAX_CELL_WIDTH; i++) begin
      if (a_mask_r[i]) begin
        hi_idx    = COL_W'(i);
        ink_found = 1'b1;
      end
    end
    b_trail_nxt = ink_found ? (eff_w - CNT_W'(1) - CNT_W'(hi_idx)) : eff_w;
  end

  // Stage B: edges and the three position products.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (b_en) begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (b_en && a_valid_r) begin
      b_lead_r      <= b_lead_nxt;
      b_trail_r     <= b_trail_nxt;
      b_prod_x_r    <= (CELL_POS_W+CELL_SIZE_W)'(a_cell_col_r) *
                       (CELL_POS_W+CELL_SIZE_W)'(eff_w);
      b_prod_y_r    <= (CELL_POS_W+CELL_SIZE_W)'(a_cell_row_r) *
                       (CELL_POS_W+CELL_SIZE_W)'(eff_h);
      b_prod_n_r    <= (CELL_POS_W+CELL_COUNT_W)'(a_cell_row_r) *
                       (CELL_POS_W+CELL_COUNT_W)'(eff_across);
      b_run_start_r <= a_run_start_r;
      b_run_end_r   <= a_run_end_r;
      b_cell_col_r  <= a_cell_col_r;
    end
  end

  // Left edge is one less than the leading clear count, or zero.
  assign ink_start = (b_lead_r != '0) ? (b_lead_r - CNT_W'(1)) : '0;

  // Output register: final offsets and sums of the glyph record.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_en) begin
      out_valid_r <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en && b_valid_r) begin
      glyph_number_r <= GLYPH_NUM_W'(b_prod_n_r + (CELL_POS_W+CELL_COUNT_W)'(b_cell_col_r));
      advance_r      <= b_run_end_r - ADVANCE_W'(b_run_start_r);
      bearing_r      <= b_run_start_r - signed'(BEARING_W'(ink_start));
      atlas_x_r      <= TEX_COORD_W'(b_prod_x_r + (CELL_POS_W+CELL_SIZE_W)'(ink_start));
      atlas_y_r      <= TEX_COORD_W'(b_prod_y_r);
      glyph_width_r  <= signed'(GLYPH_WIDTH_W'(eff_w) - GLYPH_WIDTH_W'(ink_start) -
                                GLYPH_WIDTH_W'(b_trail_r));
      glyph_height_r <= GLYPH_HEIGHT_W'(eff_h - CELL_SIZE_W'(1));
    end
  end

  assign out_glyph.valid        = out_valid_r;
  assign out_glyph.glyph_number = glyph_number_r;
  assign out_glyph.advance      = advance_r;
  assign out_glyph.bearing      = bearing_r;
  assign out_glyph.atlas_x      = atlas_x_r;
  assign out_glyph.atlas_y      = atlas_y_r;
  assign out_glyph.glyph_width  = glyph_width_r;
  assign out_glyph.glyph_height = glyph_height_r;

endmodule

`default_nettype wire

>>> test/tb_font_cell_glyph_metrics.sv
`timescale 1ns / 1ps

module tb_font_cell_glyph_metrics;
  import fcgm_pkg::*;

  // Glyph record as it leaves the block.
  typedef struct packed {
    logic        [GLYPH_NUM_W-1:0]    glyph_number;
    logic        [ADVANCE_W-1:0]      advance;
    logic signed [BEARING_W-1:0]      bearing;
    logic        [TEX_COORD_W-1:0]    atlas_x;
    logic        [TEX_COORD_W-1:0]    atlas_y;
    logic signed [GLYPH_WIDTH_W-1:0]  glyph_width;
    logic        [GLYPH_HEIGHT_W-1:0] glyph_height;
  } glyph_rec_t;

  // Pacing of the two streaming channels.
  typedef enum int {PACE_FREE, PACE_SENDER_GAPS, PACE_RECEIVER_STALLS, PACE_BOTH} pace_t;

  localparam logic [CFG_IDX_W-1:0] FIRST_UNUSED_REG = CFG_IDX_W'(int'(REG_CELLS_DOWN) + 1);
  localparam logic [CFG_IDX_W-1:0] LAST_REG_INDEX   = CFG_IDX_W'((1 << CFG_IDX_W) - 1);
  localparam int DRAIN_CYCLES = 8;

  logic clk;
  logic rst_n;

  fcgm_pixel_if in_pix ();
  fcgm_glyph_if out_glyph ();
  fcgm_cfg_if   cfg_wr ();

  font_cell_glyph_metrics u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_pix    (in_pix),
    .out_glyph (out_glyph),
    .cfg_wr    (cfg_wr)
  );

  // Stimulus and scoreboard storage.
  logic [ALPHA_W-1:0] pending_pixels[$];
  glyph_rec_t         expected_glyphs[$];
  int                 pixels_queued;
  int                 pixels_taken;
  int                 mismatches;
  int                 sender_gap_pct;
  int                 receiver_stall_pct;
  int                 phase_count;

  // Shadow copy of the registers and of the per-cell tracking state.
  logic [CELL_SIZE_W-1:0]  shadow_width;
  logic [CELL_SIZE_W-1:0]  shadow_height;
  logic [CELL_COUNT_W-1:0] shadow_across;
  logic [CELL_COUNT_W-1:0] shadow_down;
  logic [63:0]             inked_columns;
  int                      col_pos;
  int                      row_pos;
  int                      cell_col;
  int                      cell_row;
  int                      clear_run_start;
  int                      clear_run_end;
  bit                      clear_run_done;

  // Short cells of 2x2 pixels: ink row first, metrics row second.
  logic [ALPHA_W-1:0] directed_pixels [24] = '{
    8'h00, 8'h00, 8'h00, 8'h00,
    8'hFF, 8'hFF, 8'hFF, 8'hFF,
    8'h01, 8'h00, 8'hFF, 8'h00,
    8'h00, 8'h80, 8'h00, 8'h07,
    8'h80, 8'h7F, 8'h00, 8'h00,
    8'h00, 8'h55, 8'hAA, 8'h00
  };

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic int clamp_to(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int cell_w();
    return clamp_to(int'(shadow_width), 2, MAX_CELL_WIDTH_DEF);
  endfunction

  function automatic int cell_h();
    return clamp_to(int'(shadow_height), 2, 64);
  endfunction

  function automatic int cells_x();
    return clamp_to(int'(shadow_across), 1, 256);
  endfunction

  function automatic int cells_y();
    return clamp_to(int'(shadow_down), 1, 256);
  endfunction

  function automatic void clear_cell_state();
    inked_columns   = '0;
    clear_run_start = -1;
    clear_run_end   = cell_w();
    clear_run_done  = 1'b0;
  endfunction

  function automatic void restart_stream();
    col_pos  = 0;
    row_pos  = 0;
    cell_col = 0;
    cell_row = 0;
    clear_cell_state();
  endfunction

  // A write to a known register restarts the stream; other indexes do nothing.
  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_CELL_WIDTH:   shadow_width  = val[CELL_SIZE_W-1:0];
      REG_CELL_HEIGHT:  shadow_height = val[CELL_SIZE_W-1:0];
      REG_CELLS_ACROSS: shadow_across = val[CELL_COUNT_W-1:0];
      REG_CELLS_DOWN:   shadow_down   = val[CELL_COUNT_W-1:0];
      default: return;
    endcase
    restart_stream();
  endfunction

  // Advances the shadow state by one pixel and queues a record at the end of a cell.
  function automatic void track_pixel(logic [ALPHA_W-1:0] alpha);
    int w;
    int h;
    int x;
    int lead;
    int trail;
    int ink_start;
    int gw;
    glyph_rec_t rec;
    w = cell_w();
    h = cell_h();
    x = col_pos & 63;

    // Ink rows mark columns; the metrics row looks for the first clear run.
    if (row_pos + 1 < h) begin
      if (alpha != 0) inked_columns[x] = 1'b1;
    end else if (clear_run_start < 0) begin
      if (alpha == 0) clear_run_start = x;
    end else if (!clear_run_done && alpha != 0) begin
      clear_run_end  = x;
      clear_run_done = 1'b1;
    end

    if (col_pos + 1 >= w && row_pos + 1 >= h) begin
      lead = 0;
      while (lead < w && !inked_columns[lead]) lead++;
      trail = 0;
      for (int i = w; i > 0 && !inked_columns[i-1]; i--) trail++;
      ink_start = (lead > 0) ? lead - 1 : 0;
      gw = w - ink_start - trail;

      rec.glyph_number = GLYPH_NUM_W'(cell_row * cells_x() + cell_col);
      rec.advance      = ADVANCE_W'(clear_run_end - clear_run_start);
      rec.bearing      = BEARING_W'(clear_run_start - ink_start);
      rec.atlas_x      = TEX_COORD_W'(cell_col * w + ink_start);
      rec.atlas_y      = TEX_COORD_W'(cell_row * h);
      rec.glyph_width  = GLYPH_WIDTH_W'(gw);
      rec.glyph_height = GLYPH_HEIGHT_W'(h - 1);
      expected_glyphs = {expected_glyphs, rec};

      clear_cell_state();
      col_pos = 0;
      row_pos = 0;
      cell_col++;
      if (cell_col >= cells_x()) begin
        cell_col = 0;
        cell_row++;
        if (cell_row >= cells_y()) cell_row = 0;
      end
    end else if (col_pos + 1 >= w) begin
      col_pos = 0;
      row_pos++;
    end else begin
      col_pos++;
    end
  endfunction

  // Pixel driver: one transaction per accepted pixel, with random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_pix.valid <= 1'b0;
    end else begin
      if (in_pix.valid && in_pix.ready) begin
        track_pixel(in_pix.pixel_alpha);
        pixels_taken++;
      end
      if (!in_pix.valid || in_pix.ready) begin
        if (pending_pixels.size() != 0 && $urandom_range(99) >= sender_gap_pct) begin
          in_pix.valid       <= 1'b1;
          in_pix.pixel_alpha <= pending_pixels.pop_front();
        end else begin
          in_pix.valid <= 1'b0;
        end
      end
    end
  end

  task automatic report_field(input string field, input int want, input int got);
    $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
    mismatches++;
  endtask

  // Record monitor: compares each transaction with the oldest expectation.
  always @(posedge clk) begin
    glyph_rec_t want;
    if (!rst_n) begin
      out_glyph.ready <= 1'b0;
    end else begin
      if (out_glyph.valid && out_glyph.ready) begin
        if (expected_glyphs.size() == 0) begin
          $display("%0t: unexpected glyph record, glyph_number %0d", $time,
                   out_glyph.glyph_number);
          mismatches++;
        end else begin
          want = expected_glyphs.pop_front();
          if (out_glyph.glyph_number !== want.glyph_number)
            report_field("glyph_number", int'(want.glyph_number),
                         int'(out_glyph.glyph_number));
          if (out_glyph.advance !== want.advance)
            report_field("advance", int'(want.advance), int'(out_glyph.advance));
          if (out_glyph.bearing !== want.bearing)
            report_field("bearing", int'(want.bearing), int'(out_glyph.bearing));
          if (out_glyph.atlas_x !== want.atlas_x)
            report_field("atlas_x", int'(want.atlas_x), int'(out_glyph.atlas_x));
          if (out_glyph.atlas_y !== want.atlas_y)
            report_field("atlas_y", int'(want.atlas_y), int'(out_glyph.atlas_y));
          if (out_glyph.glyph_width !== want.glyph_width)
            report_field("glyph_width", int'(want.glyph_width),
                         int'(out_glyph.glyph_width));
          if (out_glyph.glyph_height !== want.glyph_height)
            report_field("glyph_height", int'(want.glyph_height),
                         int'(out_glyph.glyph_height));
        end
      end
      out_glyph.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // One register transaction; valid is left high for a following write.
  task automatic cfg_send(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_wr.valid <= 1'b1;
    cfg_wr.index <= idx;
    cfg_wr.data  <= val;
    @(posedge clk);
    while (!cfg_wr.ready) @(posedge clk);
    apply_reg(idx, val);
  endtask

  task automatic program_cells(input int w, input int h, input int across, input int down);
    @(posedge clk);
    cfg_send(REG_CELL_WIDTH, CFG_DATA_W'(w));
    cfg_send(REG_CELL_HEIGHT, CFG_DATA_W'(h));
    cfg_send(REG_CELLS_ACROSS, CFG_DATA_W'(across));
    cfg_send(REG_CELLS_DOWN, CFG_DATA_W'(down));
    cfg_wr.valid <= 1'b0;
  endtask

  function automatic void push_pixel(logic [ALPHA_W-1:0] alpha);
    pending_pixels = {pending_pixels, alpha};
    pixels_queued++;
  endfunction

  function automatic logic [ALPHA_W-1:0] ink_alpha();
    case ($urandom_range(3))
      0: return 8'hFF;
      1: return ALPHA_W'($urandom_range(15, 1));
      default: return ALPHA_W'($urandom_range(255, 1));
    endcase
  endfunction

  // One well-formed cell: ink columns of a random shape, then a metrics row.
  function automatic void queue_cell(int w, int h);
    logic [63:0] cols;
    int density;
    int lo;
    int hi;
    int metric_mode;
    lo = $urandom_range(w - 1);
    hi = $urandom_range(w - 1, lo);
    density = $urandom_range(100, 20);
    case ($urandom_range(4))
      0: cols = '0;
      1: begin
        cols    = '1;
        density = 100;
      end
      2: cols = (64'(1) << (hi + 1)) - (64'(1) << lo);
      3: cols = {$urandom, $urandom};
      default: cols = 64'(1) << lo;
    endcase
    for (int r = 0; r < h - 1; r++)
      for (int c = 0; c < w; c++)
        push_pixel((cols[c] && $urandom_range(99) < density) ? ink_alpha() : '0);

    // Metrics row: opaque, clear, one clear run, or noise.
    metric_mode = $urandom_range(3);
    hi = $urandom_range(w, lo);
    for (int c = 0; c < w; c++) begin
      case (metric_mode)
        0: push_pixel(ink_alpha());
        1: push_pixel('0);
        2: push_pixel((c >= lo && c < hi) ? '0 : ink_alpha());
        default: push_pixel($urandom_range(1) ? '0 : ink_alpha());
      endcase
    end
  endfunction

  // Queues whole cells until a pixel budget is met, then an optional ragged tail.
  task automatic feed(input int min_pixels, input int tail);
    int w;
    int h;
    int count;
    case (pace_t'(phase_count % 4))
      PACE_FREE: begin
        sender_gap_pct     = 0;
        receiver_stall_pct = 0;
      end
      PACE_SENDER_GAPS: begin
        sender_gap_pct     = 56;
        receiver_stall_pct = 0;
      end
      PACE_RECEIVER_STALLS: begin
        sender_gap_pct     = 0;
        receiver_stall_pct = 56;
      end
      default: begin
        sender_gap_pct     = 8;
        receiver_stall_pct = 8;
      end
    endcase
    phase_count++;
    w = cell_w();
    h = cell_h();
    count = 0;
    do begin
      queue_cell(w, h);
      count += w * h;
    end while (count < min_pixels);
    repeat (tail) push_pixel(ALPHA_W'($urandom_range(255)));
  endtask

  // Waits until every pixel is taken and every record has arrived.
  task automatic drain();
    @(posedge clk);
    while (pixels_taken != pixels_queued || expected_glyphs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    in_pix.valid       = 1'b0;
    in_pix.pixel_alpha = '0;
    out_glyph.ready    = 1'b0;
    cfg_wr.valid       = 1'b0;
    cfg_wr.index       = '0;
    cfg_wr.data        = '0;
    rst_n              = 1'b0;
    pixels_queued      = 0;
    pixels_taken       = 0;
    mismatches         = 0;
    phase_count        = 0;
    sender_gap_pct     = 0;
    receiver_stall_pct = 0;
    shadow_width       = 7'd8;
    shadow_height      = 7'd8;
    shadow_across      = 9'd16;
    shadow_down        = 9'd16;
    restart_stream();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Register values after reset.
    feed(64, 0);
    drain();

    // Directed 2x2 cells: empty, solid, edge runs and bit patterns.
    program_cells(2, 2, 2, 2);
    sender_gap_pct     = 0;
    receiver_stall_pct = 0;
    foreach (directed_pixels[i]) push_pixel(directed_pixels[i]);
    drain();

    // Extreme and saturated register settings.
    program_cells(1, 200, 511, 300);
    feed(1, 0);
    drain();
    program_cells(0, 1, 0, 0);
    feed(8, 3);
    drain();
    program_cells(200, 0, 256, 1);
    feed(1, 0);
    drain();
    program_cells(2, 2, 256, 2);
    feed(40, 0);
    drain();

    // A write to an unused index must leave the stream where it was.
    program_cells(4, 3, 3, 2);
    feed(24, 5);
    drain();
    @(posedge clk);
    cfg_send(CFG_IDX_W'($urandom_range(LAST_REG_INDEX, FIRST_UNUSED_REG)),
             CFG_DATA_W'($urandom));
    cfg_wr.valid <= 1'b0;
    feed(24, 0);
    drain();

    // Random settings with small cells and ragged tails.
    for (int p = 0; p < 6; p++) begin
      program_cells($urandom_range(8, 2), $urandom_range(6, 2), $urandom_range(4, 1),
                    $urandom_range(3, 1));
      feed(20, $urandom_range(1) ? $urandom_range(5, 1) : 0);
      drain();
    end

    if (mismatches == 0 && expected_glyphs.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #1000000;
    $display("FAILURE");
    $finish;
  end

endmodule
